FILE: rtl/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared constants and types for the Q24.8 fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  // Word format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;

  // One unit in the last place, for inc/dec
  localparam logic [WORD_BITS-1:0] ULP = WORD_BITS'(1);

  // One divider cell per dividend bit (operand magnitude shifted left)
  localparam int DVD_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DIV_STEPS = DVD_BITS;

  // Operation codes
  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_LT       = 4'd4,
    CMD_GT       = 4'd5,
    CMD_LE       = 4'd6,
    CMD_GE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

  // Word carried from cell to cell down the divider chain
  typedef struct packed {
    logic                 valid;
    logic                 is_div;   // quotient replaces res at the end
    logic                 neg;      // operand signs differ
    logic                 flag;
    logic                 status;
    logic [WORD_BITS-1:0] res;      // finished result of non-divide ops
    logic [WORD_BITS-1:0] rem;      // partial remainder
    logic [WORD_BITS-1:0] quo;      // low quotient bits so far
    logic [DVD_BITS-1:0]  dvd;      // dividend bits not yet consumed, msb first
    logic [WORD_BITS-1:0] dsr;      // divisor magnitude
  } cell_t;

endpackage

FILE: rtl/fxalu_in_if.sv
// ----------------------------------------------------------------------------
// fxalu_in_if
// Operation channel: valid/ready with command and two raw Q24.8 operands.
// ----------------------------------------------------------------------------
interface fxalu_in_if;

  logic                                   valid;
  logic                                   ready;
  fxalu_pkg::cmd_t                        cmd;
  logic signed [fxalu_pkg::WORD_BITS-1:0] operand_a;
  logic signed [fxalu_pkg::WORD_BITS-1:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input cmd, input operand_a, input operand_b,
                  output ready);

endinterface

FILE: rtl/fxalu_out_if.sv
// ----------------------------------------------------------------------------
// fxalu_out_if
// Result channel: valid/ready with result word, compare flag and status.
// ----------------------------------------------------------------------------
interface fxalu_out_if;

  logic                                   valid;
  logic                                   ready;
  logic signed [fxalu_pkg::WORD_BITS-1:0] result_word;
  logic                                   compare_flag;
  logic                                   status;

  modport source (output valid, output result_word, output compare_flag,
                  output status, input ready);
  modport sink   (input valid, input result_word, input compare_flag,
                  input status, output ready);

endinterface

FILE: rtl/fxalu_front.sv
// ----------------------------------------------------------------------------
// fxalu_front
// Input skid, operand register and the non-divide ops (incl. multiply).
// Emits the first word of the divider chain.
// ----------------------------------------------------------------------------
module fxalu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  fxalu_in_if.sink          in_ch,
  output fxalu_pkg::cell_t  cell_out
);

  // skid slot, filled only while the pipeline is held
  logic                                   skid_v_r;
  fxalu_pkg::cmd_t                        skid_cmd_r;
  logic signed [fxalu_pkg::WORD_BITS-1:0] skid_a_r;
  logic signed [fxalu_pkg::WORD_BITS-1:0] skid_b_r;

  // operand stage
  logic                                   s0_v_r;
  fxalu_pkg::cmd_t                        s0_cmd_r;
  logic signed [fxalu_pkg::WORD_BITS-1:0] s0_a_r;
  logic signed [fxalu_pkg::WORD_BITS-1:0] s0_b_r;

  logic                                     accept;
  logic signed [2*fxalu_pkg::WORD_BITS-1:0] prod;
  logic                                     a_lt_b;
  logic                                     b_lt_a;
  logic [fxalu_pkg::WORD_BITS-1:0]          a_mag;
  logic [fxalu_pkg::WORD_BITS-1:0]          b_mag;
  fxalu_pkg::cell_t                         cell_nxt;
  fxalu_pkg::cell_t                         cell_r;

  assign in_ch.ready = !skid_v_r;
  assign accept      = in_ch.valid && !skid_v_r;

  // skid and operand control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      s0_v_r   <= 1'b0;
    end else if (adv) begin
      skid_v_r <= 1'b0;
      s0_v_r   <= skid_v_r || in_ch.valid;
    end else begin
      skid_v_r <= skid_v_r || accept;
    end
  end

  // skid and operand payload
  always_ff @(posedge clk) begin
    if (!adv && accept) begin
      skid_cmd_r <= in_ch.cmd;
      skid_a_r   <= in_ch.operand_a;
      skid_b_r   <= in_ch.operand_b;
    end
    if (adv) begin
      s0_cmd_r <= skid_v_r ? skid_cmd_r : in_ch.cmd;
      s0_a_r   <= skid_v_r ? skid_a_r   : in_ch.operand_a;
      s0_b_r   <= skid_v_r ? skid_b_r   : in_ch.operand_b;
    end
  end

  // shared arithmetic
  assign prod   = (2*fxalu_pkg::WORD_BITS)'(s0_a_r) * (2*fxalu_pkg::WORD_BITS)'(s0_b_r);
  assign a_lt_b = s0_a_r < s0_b_r;
  assign b_lt_a = s0_b_r < s0_a_r;
  assign a_mag  = s0_a_r[fxalu_pkg::WORD_BITS-1] ? -s0_a_r : s0_a_r;
  assign b_mag  = s0_b_r[fxalu_pkg::WORD_BITS-1] ? -s0_b_r : s0_b_r;

  // op select; divide only seeds the chain
  always_comb begin
    cell_nxt        = '0;
    cell_nxt.valid  = s0_v_r;
    cell_nxt.neg    = s0_a_r[fxalu_pkg::WORD_BITS-1] ^ s0_b_r[fxalu_pkg::WORD_BITS-1];
    cell_nxt.dvd    = {a_mag, {fxalu_pkg::FRAC_BITS{1'b0}}};
    cell_nxt.dsr    = b_mag;
    case (s0_cmd_r)
      fxalu_pkg::CMD_ADD: cell_nxt.res = s0_a_r + s0_b_r;
      fxalu_pkg::CMD_SUB: cell_nxt.res = s0_a_r - s0_b_r;
      fxalu_pkg::CMD_MUL:
        cell_nxt.res = prod[fxalu_pkg::WORD_BITS+fxalu_pkg::FRAC_BITS-1:fxalu_pkg::FRAC_BITS];
      fxalu_pkg::CMD_DIV: begin
        if (s0_b_r == '0) begin
          cell_nxt.status = 1'b1;
        end else begin
          cell_nxt.is_div = 1'b1;
        end
      end
      fxalu_pkg::CMD_LT:  cell_nxt.flag = a_lt_b;
      fxalu_pkg::CMD_GT:  cell_nxt.flag = b_lt_a;
      fxalu_pkg::CMD_LE:  cell_nxt.flag = !b_lt_a;
      fxalu_pkg::CMD_GE:  cell_nxt.flag = !a_lt_b;
      fxalu_pkg::CMD_EQ:  cell_nxt.flag = (s0_a_r == s0_b_r);
      fxalu_pkg::CMD_NE:  cell_nxt.flag = (s0_a_r != s0_b_r);
      fxalu_pkg::CMD_MIN: cell_nxt.res = a_lt_b ? s0_a_r : s0_b_r;
      fxalu_pkg::CMD_MAX: cell_nxt.res = b_lt_a ? s0_a_r : s0_b_r;
      fxalu_pkg::CMD_INC: cell_nxt.res = s0_a_r + fxalu_pkg::ULP;
      fxalu_pkg::CMD_DEC: cell_nxt.res = s0_a_r - fxalu_pkg::ULP;
      fxalu_pkg::CMD_FROM_INT: cell_nxt.res = s0_a_r <<< fxalu_pkg::FRAC_BITS;
      fxalu_pkg::CMD_TO_INT:   cell_nxt.res = s0_a_r >>> fxalu_pkg::FRAC_BITS;
      default: cell_nxt.res = '0;
    endcase
  end

  // result stage feeding the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

FILE: rtl/fxalu_cell.sv
// ----------------------------------------------------------------------------
// fxalu_cell
// One restoring-division step: shifts in the next dividend bit, trial
// subtracts the divisor and appends a quotient bit. Other words pass along.
// ----------------------------------------------------------------------------
module fxalu_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  fxalu_pkg::cell_t  cell_in,
  output fxalu_pkg::cell_t  cell_out
);

  logic [fxalu_pkg::WORD_BITS:0]   rem_sh;
  logic [fxalu_pkg::WORD_BITS+1:0] diff;
  logic                            fits;
  fxalu_pkg::cell_t                cell_nxt;
  fxalu_pkg::cell_t                cell_r;

  // trial subtract
  assign rem_sh = {cell_in.rem, cell_in.dvd[fxalu_pkg::DVD_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, cell_in.dsr};
  assign fits   = !diff[fxalu_pkg::WORD_BITS+1];

  always_comb begin
    cell_nxt     = cell_in;
    cell_nxt.rem = fits ? diff[fxalu_pkg::WORD_BITS-1:0]
                        : rem_sh[fxalu_pkg::WORD_BITS-1:0];
    cell_nxt.quo = {cell_in.quo[fxalu_pkg::WORD_BITS-2:0], fits};
    cell_nxt.dvd = {cell_in.dvd[fxalu_pkg::DVD_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

FILE: rtl/fxalu_back.sv
// ----------------------------------------------------------------------------
// fxalu_back
// Output register: applies the quotient sign and holds the result word.
// Generates the pipeline advance.
// ----------------------------------------------------------------------------
module fxalu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fxalu_pkg::cell_t  cell_in,
  output logic              adv,
  fxalu_out_if.source       out_ch
);

  logic                            out_v_r;
  logic [fxalu_pkg::WORD_BITS-1:0] res_r;
  logic                            flag_r;
  logic                            status_r;
  logic [fxalu_pkg::WORD_BITS-1:0] quo_signed;
  logic [fxalu_pkg::WORD_BITS-1:0] res_nxt;

  assign adv = !out_v_r || out_ch.ready;

  // quotient truncates toward zero, sign applied last
  assign quo_signed = cell_in.neg ? -cell_in.quo : cell_in.quo;
  assign res_nxt    = cell_in.is_div ? quo_signed : cell_in.res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r  <= cell_in.valid;
      res_r    <= res_nxt;
      flag_r   <= cell_in.flag;
      status_r <= cell_in.status;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_word  = res_r;
  assign out_ch.compare_flag = flag_r;
  assign out_ch.status       = status_r;

endmodule

FILE: rtl/fixed_point_q24_8_alu.sv
// Throughput: one word per cycle while out_ch is not held; every op takes the
//   same path, through the operand register, the front result stage, the
//   divider chain of 40 cells (one quotient bit per cell) and the output
//   register.
// A held output parks one more word in the input skid slot before in_ready drops.
// Reset (synchronous, active low) empties every stage; no result is pending.
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Q24.8 fixed-point ALU: add/sub/mul/div, compares, min/max, inc/dec and
// integer conversions, pipelined through a chain of division cells.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu (
  input  logic        clk,
  input  logic        rst_n,
  fxalu_in_if.sink    in_ch,
  fxalu_out_if.source out_ch
);

  logic             adv;
  fxalu_pkg::cell_t chain [0:fxalu_pkg::DIV_STEPS];

  // operand capture and non-divide ops
  fxalu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_ch    (in_ch),
    .cell_out (chain[0])
  );

  // division cells
  for (genvar i = 0; i < fxalu_pkg::DIV_STEPS; i++) begin : g_cell
    fxalu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  // result register
  fxalu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cell_in (chain[fxalu_pkg::DIV_STEPS]),
    .adv     (adv),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/fxalu_checker.sv
// ----------------------------------------------------------------------------
// fxalu_checker
// Port-level checks for the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fxalu_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [fxalu_pkg::WORD_BITS-1:0] out_result_word,
  input logic                                   out_compare_flag,
  input logic                                   out_status
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_word)
      && $stable(out_compare_flag) && $stable(out_status))
    else $error("result word changed while held");

  // input only backs off after the output was held
  a_in_backoff: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input not ready without output back-pressure");

  // divide-by-zero word is zero and not a comparison
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_result_word == '0 && !out_compare_flag)
    else $error("error status with nonzero result or flag");

  // a true comparison carries a zero word
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_flag |-> out_result_word == '0)
    else $error("comparison result with nonzero word");

endmodule

bind fixed_point_q24_8_alu fxalu_checker u_fxalu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_word  (out_ch.result_word),
  .out_compare_flag (out_ch.compare_flag),
  .out_status       (out_ch.status)
);

FILE: tb/sv/tb_fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_q24_8_alu
// Self-checking bench for the Q24.8 ALU pipeline. A queue-fed driver offers
// operation words and a clocked monitor checks each result word, field by
// field and in order, against a local model of the ALU. It runs directed
// corner words, then random words under three sender/receiver idle mixes,
// with one long receiver stall.
// ----------------------------------------------------------------------------
module tb_fixed_point_q24_8_alu;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_BITS = fxalu_pkg::WORD_BITS;
  localparam int FRAC_BITS = fxalu_pkg::FRAC_BITS;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int STALL_CYCLES   = 200;
  localparam int DRAIN_CYCLES   = 60;

  localparam logic signed [WORD_BITS-1:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_BITS-1:0] MINV = 32'sh8000_0000;
  localparam logic signed [WORD_BITS-1:0] ONE  = 32'sd256;   // 1.0 in Q24.8

  typedef struct {
    fxalu_pkg::cmd_t             op;
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
  } op_word_t;

  typedef struct {
    logic [WORD_BITS-1:0] word;
    logic                 flag;
    logic                 status;
  } alu_result_t;

  logic clk;
  logic rst_n;

  fxalu_in_if  in_ch ();
  fxalu_out_if out_ch ();

  fixed_point_q24_8_alu dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  op_word_t    pending_ops[$];
  alu_result_t alu_expected[$];
  op_word_t    drive_word;

  int   send_idle_pct = 0;
  int   rcv_idle_pct  = 0;
  bit   stall_req     = 1'b0;
  int   stall_left    = 0;
  logic in_taken      = 1'b0;
  int   n_queued      = 0;
  int   n_accepted    = 0;
  int   n_checked     = 0;
  int   n_div_zero    = 0;
  int   op_seen[16];
  int   ops_covered;
  int   idle_cycles   = 0;
  int   errors        = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected result of one operation word
  function automatic alu_result_t predict_alu(fxalu_pkg::cmd_t op,
                                              logic signed [WORD_BITS-1:0] a,
                                              logic signed [WORD_BITS-1:0] b);
    alu_result_t        r;
    logic signed [63:0] prod;
    longint             mag_a;
    longint             mag_b;
    longint             quo;
    r = '{word: '0, flag: 1'b0, status: 1'b0};
    case (op)
      fxalu_pkg::CMD_ADD: r.word = a + b;
      fxalu_pkg::CMD_SUB: r.word = a - b;
      fxalu_pkg::CMD_MUL: begin
        // full product, floor shift by the fraction width
        prod   = 64'(a) * 64'(b);
        r.word = prod[FRAC_BITS +: WORD_BITS];
      end
      fxalu_pkg::CMD_DIV: begin
        if (b == 0) begin
          r.status = 1'b1;
        end else begin
          // dividend scaled up, quotient truncated toward zero
          mag_a = longint'(a);
          mag_b = longint'(b);
          if (mag_a < 0) mag_a = -mag_a;
          if (mag_b < 0) mag_b = -mag_b;
          quo = (mag_a << FRAC_BITS) / mag_b;
          if (a[WORD_BITS-1] != b[WORD_BITS-1]) quo = -quo;
          r.word = quo[WORD_BITS-1:0];
        end
      end
      fxalu_pkg::CMD_LT:       r.flag = (a < b);
      fxalu_pkg::CMD_GT:       r.flag = (a > b);
      fxalu_pkg::CMD_LE:       r.flag = (a <= b);
      fxalu_pkg::CMD_GE:       r.flag = (a >= b);
      fxalu_pkg::CMD_EQ:       r.flag = (a == b);
      fxalu_pkg::CMD_NE:       r.flag = (a != b);
      fxalu_pkg::CMD_MIN:      r.word = (a < b) ? a : b;
      fxalu_pkg::CMD_MAX:      r.word = (b < a) ? a : b;
      fxalu_pkg::CMD_INC:      r.word = a + 1;
      fxalu_pkg::CMD_DEC:      r.word = a - 1;
      fxalu_pkg::CMD_FROM_INT: r.word = a << FRAC_BITS;
      default:                 r.word = a >>> FRAC_BITS;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_BITS-1:0] got,
                                 logic [WORD_BITS-1:0] want);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic queue_word(fxalu_pkg::cmd_t op, logic signed [WORD_BITS-1:0] a,
                            logic signed [WORD_BITS-1:0] b);
    pending_ops.push_back('{op: op, a: a, b: b});
    n_queued++;
  endtask

  // Operand mix: corners, small values around zero, full-range noise
  function automatic logic signed [WORD_BITS-1:0] pick_operand();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0:       return MAXV;
          1:       return MINV;
          2:       return '0;
          3:       return 32'sd1;
          4:       return -32'sd1;
          default: return -ONE;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(65535)) - 32'sd32768;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_random(int count);
    fxalu_pkg::cmd_t             op;
    logic signed [WORD_BITS-1:0] a;
    logic signed [WORD_BITS-1:0] b;
    for (int i = 0; i < count; i++) begin
      op = fxalu_pkg::cmd_t'($urandom_range(15));
      a  = pick_operand();
      b  = ($urandom_range(9) == 0) ? a : pick_operand();
      if (op == fxalu_pkg::CMD_DIV && $urandom_range(11) == 0) b = '0;
      queue_word(op, a, b);
    end
  endtask

  // Wait until every queued word was taken and every result came back
  task automatic drain_all();
    while (n_accepted != n_queued || alu_expected.size() != 0) @(negedge clk);
  endtask

  // Driver: holds a word until taken, idles at random
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_word = pending_ops.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= drive_word.op;
        in_ch.operand_a <= drive_word.a;
        in_ch.operand_b <= drive_word.b;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_req) begin
      stall_req    = 1'b0;
      stall_left   = STALL_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        want = predict_alu(in_ch.cmd, in_ch.operand_a, in_ch.operand_b);
        alu_expected.push_back(want);
        n_accepted++;
        op_seen[in_ch.cmd]++;
        if (want.status) n_div_zero++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (alu_expected.size() == 0) begin
          report_mismatch("unexpected result word", out_ch.result_word, '0);
        end else begin
          want = alu_expected.pop_front();
          n_checked++;
          if (out_ch.result_word !== want.word)
            report_mismatch("result_word", out_ch.result_word, want.word);
          if (out_ch.compare_flag !== want.flag)
            report_mismatch("compare_flag", WORD_BITS'(out_ch.compare_flag),
                            WORD_BITS'(want.flag));
          if (out_ch.status !== want.status)
            report_mismatch("status", WORD_BITS'(out_ch.status),
                            WORD_BITS'(want.status));
        end
      end
    end
  end

  // Watchdog: cycles with no traffic on either side
  always @(posedge clk) begin
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready)) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results outstanding",
                 idle_cycles, alu_expected.size());
        $display("tb_fixed_point_q24_8_alu: errors");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Stimulus and end of run
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = fxalu_pkg::CMD_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 12;
    rcv_idle_pct  = 84;

    // corner words: wrap, floor/truncate, divide by zero, compares, conversions
    queue_word(fxalu_pkg::CMD_ADD,      MAXV,        32'sd1);
    queue_word(fxalu_pkg::CMD_ADD,      MINV,        MINV);
    queue_word(fxalu_pkg::CMD_SUB,      MINV,        32'sd1);
    queue_word(fxalu_pkg::CMD_SUB,      '0,          MINV);
    queue_word(fxalu_pkg::CMD_MUL,      MAXV,        MAXV);
    queue_word(fxalu_pkg::CMD_MUL,      MINV,        MINV);
    queue_word(fxalu_pkg::CMD_MUL,      -32'sd1,     32'sd1);
    queue_word(fxalu_pkg::CMD_MUL,      ONE * 3,     -ONE / 2);
    queue_word(fxalu_pkg::CMD_DIV,      ONE * 7,     ONE * 2);
    queue_word(fxalu_pkg::CMD_DIV,      -ONE * 7,    32'sd3);
    queue_word(fxalu_pkg::CMD_DIV,      MAXV,        '0);
    queue_word(fxalu_pkg::CMD_DIV,      MINV,        -32'sd1);
    queue_word(fxalu_pkg::CMD_DIV,      MINV,        -ONE);
    queue_word(fxalu_pkg::CMD_LT,       MINV,        MAXV);
    queue_word(fxalu_pkg::CMD_GT,       MINV,        MAXV);
    queue_word(fxalu_pkg::CMD_LE,       32'sd5,      32'sd5);
    queue_word(fxalu_pkg::CMD_GE,       -32'sd5,     -32'sd5);
    queue_word(fxalu_pkg::CMD_EQ,       MAXV,        MAXV);
    queue_word(fxalu_pkg::CMD_NE,       MINV,        MAXV);
    queue_word(fxalu_pkg::CMD_MIN,      32'sd3,      32'sd3);
    queue_word(fxalu_pkg::CMD_MIN,      MINV,        MAXV);
    queue_word(fxalu_pkg::CMD_MAX,      MINV,        MAXV);
    queue_word(fxalu_pkg::CMD_INC,      MAXV,        MINV);
    queue_word(fxalu_pkg::CMD_DEC,      MINV,        MAXV);
    queue_word(fxalu_pkg::CMD_FROM_INT, MAXV,        '0);
    queue_word(fxalu_pkg::CMD_TO_INT,   -32'sd1,     MAXV);
    queue_word(fxalu_pkg::CMD_TO_INT,   MINV,        '0);
    drain_all();

    queue_random(242);
    drain_all();

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 84;
    rcv_idle_pct  = 12;
    queue_random(242);
    drain_all();

    // no idling; long receiver hold-off fills the pipe and stalls the input
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    stall_req     = 1'b1;
    queue_random(242);
    drain_all();

    repeat (DRAIN_CYCLES) @(posedge clk);

    ops_covered = 0;
    foreach (op_seen[i]) if (op_seen[i] != 0) ops_covered++;
    $display("checked %0d results covering %0d of 16 opcodes, %0d divides by zero",
             n_checked, ops_covered, n_div_zero);
    $display("idle mixes 12/84, 84/12 and 0/0 with a %0d-cycle output hold-off",
             STALL_CYCLES);
    if (errors == 0) begin
      $display("tb_fixed_point_q24_8_alu: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_fixed_point_q24_8_alu: errors");
    end
    $finish;
  end

endmodule
